[rtl/core/ssmux_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and segment tables for the MM:SS / text display driver.
// No dependencies; used by ssmux_time_seg and seven_segment_mmss_text_mux.
package ssmux_pkg;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_SET  = 2'd1,
		ACT_TEXT = 2'd2
	} action_t;

	localparam int unsigned MAX_SECONDS      = 5999;
	localparam int unsigned DEFAULT_DURATION = 3000;
	localparam int unsigned SEC_PER_MIN      = 60;
	localparam int unsigned NUM_DIGITS       = 4;

	// Segment pattern of a decimal digit, a..g in bits 7..1.
	function automatic logic [7:0] num_seg(input logic [3:0] d);
		logic [7:0] s;
		begin
			case (d)
				4'd0: s = 8'hFC;
				4'd1: s = 8'h60;
				4'd2: s = 8'hDA;
				4'd3: s = 8'hF2;
				4'd4: s = 8'h66;
				4'd5: s = 8'hB6;
				4'd6: s = 8'hBE;
				4'd7: s = 8'hE0;
				4'd8: s = 8'hFE;
				4'd9: s = 8'hF6;
				default: s = 8'h00;
			endcase
			return s;
		end
	endfunction

	// Segment pattern of a text character; unknown characters are blank.
	function automatic logic [7:0] letter_seg(input logic [7:0] c);
		logic [7:0] s;
		begin
			case (c)
				8'h61: s = 8'hEE; // a
				8'h75: s = 8'h7C; // u
				8'h6F: s = 8'h3A; // o
				8'h66: s = 8'h8E; // f
				8'h64: s = 8'h7A; // d
				8'h6E: s = 8'h2A; // n
				8'h65: s = 8'h9E; // e
				8'h72: s = 8'h0A; // r
				8'h73: s = 8'hB6; // s
				8'h74: s = 8'h1E; // t
				default: s = 8'h00;
			endcase
			return s;
		end
	endfunction

	// Active-low digit select, upper nibble.
	function automatic logic [7:0] digit_sel(input logic [1:0] pos);
		logic [7:0] s;
		begin
			case (pos)
				2'd0: s = 8'h70;
				2'd1: s = 8'hB0;
				2'd2: s = 8'hD0;
				2'd3: s = 8'hE0;
				default: s = 8'hF0;
			endcase
			return s;
		end
	endfunction

endpackage

[rtl/core/ssmux_time_seg.sv]
`timescale 1ns / 1ps
// Segment byte of one MM:SS digit from registered minutes and seconds.
// Depends on ssmux_pkg.
module ssmux_time_seg (
	input  logic [6:0] minute,
	input  logic [5:0] sec,
	input  logic [1:0] pos,
	output logic [7:0] seg
);

	logic [14:0] min_prod;
	logic [13:0] sec_prod;
	logic [3:0]  min_tens;
	logic [3:0]  min_units;
	logic [3:0]  sec_tens;
	logic [3:0]  sec_units;
	logic [6:0]  min_tens_x10;
	logic [5:0]  sec_tens_x10;

	// x / 10 as (x * 205) >> 11, exact for x below 1029
	assign min_prod     = 15'(minute) * 15'd205;
	assign sec_prod     = 14'(sec) * 14'd205;
	assign min_tens     = min_prod[14:11];
	assign sec_tens     = {1'b0, sec_prod[13:11]};
	assign min_tens_x10 = 7'(min_tens) * 7'd10;
	assign sec_tens_x10 = 6'(sec_tens) * 6'd10;
	assign min_units    = 4'(minute - min_tens_x10);
	assign sec_units    = 4'(sec - sec_tens_x10);

	always_comb begin
		case (pos)
			2'd0: seg = ssmux_pkg::num_seg(min_tens);
			2'd1: seg = ssmux_pkg::num_seg(min_units) | 8'h01;
			2'd2: seg = ssmux_pkg::num_seg(sec_tens);
			2'd3: seg = ssmux_pkg::num_seg(sec_units) | {7'd0, sec[0]};
			default: seg = 8'h00;
		endcase
	end

endmodule

[rtl/core/ssmux_out_reg.sv]
`timescale 1ns / 1ps
// Output word register of the display driver: holds one word until taken.
// Depends on nothing but its ports.
module ssmux_out_reg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [7:0]  segments,
	input  logic [7:0]  digit_enable,
	output logic        can_load,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata  // [7:0] segments, [15:8] digit_enable
);

	logic        valid_q;
	logic [15:0] data_q;

	assign can_load      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			data_q <= {digit_enable, segments};
		end
	end

endmodule

[rtl/core/seven_segment_mmss_text_mux.sv]
`timescale 1ns / 1ps
// Four-digit multiplexed seven-segment driver, MM:SS or four text characters.
// Depends on ssmux_pkg, ssmux_time_seg and ssmux_out_reg.
//
// Usage:
//   Input words arrive on the s_axis channel; s_axis_tuser carries the action
//   (refresh tick, set time, show text) and s_axis_tdata the operands.
//   Set time and show text only update internal state and produce no word.
//   A refresh tick at digit positions 0..3 produces one 16-bit word on
//   m_axis: segment byte in bits 7..0 and active-low digit select in 15..8.
//   A tick at position 4 produces nothing and wraps the position; a tick that
//   finds the text duration exceeded drops back to time mode and produces
//   nothing.
//   Order: an accepted word is held in the input register, evaluated there and
//   its result loaded into the output register that drives m_axis.
//   Throughput: one word per cycle unless stalled; evaluation stage and
//   output register both hold a word, so input is taken while a result waits.
//   Stall: when m_axis_tready is low and the output register is full, a tick
//   that would emit holds in the input register and s_axis_tready falls;
//   words that emit nothing still drain.
//   Reset (arst_n low): time mode, 00:00, position 0, blank text, duration
//   3000 ms, both registers empty.
module seven_segment_mmss_text_mux (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] now_ms, [44:32] seconds, [52:45] char_0, [60:53] char_1,
	// [68:61] char_2, [76:69] char_3, [92:77] text_ms, [95:93] zero
	input  logic [95:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser, // [1:0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata  // [7:0] segments, [15:8] digit_enable
);

	// input register
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [92:0] data_s1;

	// display state
	logic [2:0]  mux_pos_q;
	logic        text_mode_q;
	logic [31:0] text_start_q;
	logic [15:0] text_dur_q;
	logic [6:0]  minute_q;
	logic [5:0]  sec_q;
	logic [7:0]  chars_q [ssmux_pkg::NUM_DIGITS];

	// operand fields of the held word
	logic [31:0] now_ms;
	logic [12:0] seconds;
	logic [15:0] text_ms;

	logic        is_tick;
	logic [31:0] elapsed;
	logic        expired;
	logic        show_text;
	logic        emits;
	logic        advance;
	logic        can_load;
	logic [7:0]  time_seg;
	logic [7:0]  seg;
	logic [7:0]  dig_en;

	// set-time conversion
	logic [12:0] sec_sat;
	logic [25:0] min_prod;
	logic [6:0]  set_minute;
	logic [12:0] set_min_x60;
	logic [5:0]  set_sec;

	assign now_ms  = data_s1[31:0];
	assign seconds = data_s1[44:32];
	assign text_ms = data_s1[92:77];

	assign is_tick   = valid_s1 && (action_s1 == ssmux_pkg::ACT_TICK);
	assign elapsed   = now_ms - text_start_q;
	assign expired   = text_mode_q && (elapsed > 32'(text_dur_q));
	assign show_text = text_mode_q && (elapsed < 32'(text_dur_q));
	assign emits     = is_tick && !expired && (mux_pos_q < 3'(ssmux_pkg::NUM_DIGITS));

	// advance the held word unless it emits into a full output register
	assign advance       = valid_s1 && (!emits || can_load);
	assign s_axis_tready = !valid_s1 || advance;

	// seconds / 60 as (s * 8739) >> 19, exact up to the saturation limit
	assign sec_sat     = (seconds > 13'(ssmux_pkg::MAX_SECONDS)) ?
	                     13'(ssmux_pkg::MAX_SECONDS) : seconds;
	assign min_prod    = 26'(sec_sat) * 26'd8739;
	assign set_minute  = min_prod[25:19];
	assign set_min_x60 = 13'(set_minute) * 13'(ssmux_pkg::SEC_PER_MIN);
	assign set_sec     = 6'(sec_sat - set_min_x60);

	ssmux_time_seg u_time_seg (
		.minute (minute_q),
		.sec    (sec_q),
		.pos    (mux_pos_q[1:0]),
		.seg    (time_seg)
	);

	assign seg    = show_text ? ssmux_pkg::letter_seg(chars_q[mux_pos_q[1:0]]) : time_seg;
	assign dig_en = ssmux_pkg::digit_sel(mux_pos_q[1:0]);

	ssmux_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (emits && advance),
		.segments      (seg),
		.digit_enable  (dig_en),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// capture a word whenever the stage is free or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= s_axis_tuser;
			data_s1   <= s_axis_tdata[92:0];
		end
	end

	// state update as the held word leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mux_pos_q    <= 3'd0;
			text_mode_q  <= 1'b0;
			text_start_q <= 32'd0;
			text_dur_q   <= 16'(ssmux_pkg::DEFAULT_DURATION);
			minute_q     <= 7'd0;
			sec_q        <= 6'd0;
			for (int i = 0; i < ssmux_pkg::NUM_DIGITS; i++) begin
				chars_q[i] <= 8'd0;
			end
		end else if (advance) begin
			case (action_s1)
				ssmux_pkg::ACT_SET: begin
					minute_q <= set_minute;
					sec_q    <= set_sec;
				end
				ssmux_pkg::ACT_TEXT: begin
					chars_q[0]   <= data_s1[52:45];
					chars_q[1]   <= data_s1[60:53];
					chars_q[2]   <= data_s1[68:61];
					chars_q[3]   <= data_s1[76:69];
					text_dur_q   <= text_ms;
					text_start_q <= now_ms;
					text_mode_q  <= 1'b1;
				end
				ssmux_pkg::ACT_TICK: begin
					if (expired) begin
						// text timed out: back to time, no word this tick
						text_start_q <= now_ms;
						text_mode_q  <= 1'b0;
					end else if (emits) begin
						mux_pos_q <= mux_pos_q + 3'd1;
					end else begin
						mux_pos_q <= 3'd0;
					end
				end
				default: begin
					// unused action: drop
				end
			endcase
		end
	end

endmodule

[verif/seven_segment_mmss_text_mux_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the MM:SS / text seven-segment multiplexer.
// Depends on ssmux_pkg and seven_segment_mmss_text_mux; predicts every digit word in-bench.
module seven_segment_mmss_text_mux_test;
	import ssmux_pkg::*;

	// Action code the block ignores; the package only names the three live ones.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int unsigned RANDOM_WORDS = 1100;
	localparam int unsigned CALM_TAIL    = 150;   // last words run with no idling
	localparam int unsigned HOLD_AT      = 400;   // words taken before the long hold-off
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 8;     // plenty of margin for a stray output word
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned REPORT_CAP   = 40;

	// Segment patterns of 0..9, a..g in bits 7..1.
	localparam logic [7:0] DIGIT_SEGS [10] = '{
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
	};
	// Active-low select of digits 0..3 (left to right).
	localparam logic [7:0] DIGIT_PICK [4] = '{8'h70, 8'hB0, 8'hD0, 8'hE0};
	// The only characters with a pattern of their own.
	localparam logic [7:0] LETTER_CODES [10] = '{
		"a", "u", "o", "f", "d", "n", "e", "r", "s", "t"
	};

	// One input word, fields as the bus carries them; chars[0] is the leftmost digit.
	typedef struct packed {
		logic [1:0]       action;
		logic [31:0]      now_ms;
		logic [12:0]      seconds;
		logic [3:0][7:0]  chars;
		logic [15:0]      text_ms;
	} stim_t;

	// One digit word as it leaves the block.
	typedef struct packed {
		logic [7:0] digit_enable;
		logic [7:0] segments;
	} shown_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = ACT_TICK;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	seven_segment_mmss_text_mux dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stimulus and expectation stores.
	stim_t       words_to_send [$];
	shown_t      digits_due [$];
	stim_t       on_bus;          // word currently offered on s_axis
	bit          offering = 1'b0;
	bit          took_in = 1'b0;  // s_axis handshake at the last rising edge
	int unsigned words_in = 0;
	int unsigned total_words = 0;
	int unsigned mismatches = 0;
	logic [31:0] gen_ms = '0;     // stimulus-side millisecond clock

	// Predicted display state.
	logic [2:0]       disp_pos = '0;
	bit               text_on = 1'b0;
	logic [31:0]      text_t0 = '0;
	logic [15:0]      text_len = 16'(DEFAULT_DURATION);
	logic [12:0]      clock_secs = '0;
	logic [3:0][7:0]  text_bytes = '0;

	// Idle control.
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	bit          calm;
	bit          gaps_on;
	bit          stalls_on;

	// Idling comes and goes in stretches, and stops for the tail of the run.
	assign calm      = (words_in + CALM_TAIL >= total_words);
	assign gaps_on   = ((words_in / 128) % 3) != 1;
	assign stalls_on = ((words_in / 96) % 3) != 2;

	task automatic flag_mismatch(input string what);
		if (mismatches < REPORT_CAP)
			$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic logic [7:0] char_pattern(input logic [7:0] c);
		case (c)
			"a": return 8'hEE;
			"u": return 8'h7C;
			"o": return 8'h3A;
			"f": return 8'h8E;
			"d": return 8'h7A;
			"n": return 8'h2A;
			"e": return 8'h9E;
			"r": return 8'h0A;
			"s": return 8'hB6;
			"t": return 8'h1E;
			default: return 8'h00;
		endcase
	endfunction

	// Digit of MM:SS at a position; minutes carry the colon dot, odd seconds the last dot.
	function automatic logic [7:0] clock_pattern(input logic [12:0] secs, input logic [1:0] pos);
		int unsigned mins;
		int unsigned sec;
		mins = secs / SEC_PER_MIN;
		sec  = secs % SEC_PER_MIN;
		case (pos)
			2'd0: return DIGIT_SEGS[(mins / 10) % 10];
			2'd1: return DIGIT_SEGS[mins % 10] | 8'h01;
			2'd2: return DIGIT_SEGS[sec / 10];
			default: return DIGIT_SEGS[sec % 10] | 8'(sec & 1);
		endcase
	endfunction

	// Apply one accepted word to the predicted display and queue the digit it lights.
	task automatic advance_display(input stim_t w);
		logic [31:0] elapsed;
		bit          lit;
		bit          from_text;
		shown_t      d;
		lit = 1'b0;
		from_text = 1'b0;
		if (w.action == ACT_SET) begin
			clock_secs = (w.seconds > MAX_SECONDS) ? 13'(MAX_SECONDS) : w.seconds;
		end else if (w.action == ACT_TEXT) begin
			text_bytes = w.chars;
			text_len   = w.text_ms;
			text_t0    = w.now_ms;
			text_on    = 1'b1;
		end else if (w.action == ACT_TICK) begin
			lit = 1'b1;
			if (text_on) begin
				elapsed = w.now_ms - text_t0;
				if (elapsed < {16'd0, text_len}) begin
					from_text = 1'b1;
				end else if (elapsed > {16'd0, text_len}) begin
					// text has run out: drop back to time mode silently, position held
					text_t0 = w.now_ms;
					text_on = 1'b0;
					lit = 1'b0;
				end
			end
			if (lit) begin
				if (disp_pos >= 3'(NUM_DIGITS)) begin
					disp_pos = '0;
				end else begin
					d.segments = from_text ? char_pattern(text_bytes[disp_pos[1:0]])
						: clock_pattern(clock_secs, disp_pos[1:0]);
					d.digit_enable = DIGIT_PICK[disp_pos[1:0]];
					digits_due.push_back(d);
					disp_pos = disp_pos + 3'd1;
				end
			end
		end
	endtask

	// Stimulus builders: fields a word does not use are filled with noise.
	function automatic stim_t junk_word();
		stim_t w;
		w.action  = 2'($urandom_range(0, 3));
		w.now_ms  = $urandom;
		w.seconds = 13'($urandom);
		w.chars   = $urandom;
		w.text_ms = 16'($urandom);
		return w;
	endfunction

	task automatic queue_tick(input logic [31:0] ms);
		stim_t w;
		w = junk_word();
		w.action = ACT_TICK;
		w.now_ms = ms;
		words_to_send.push_back(w);
	endtask

	task automatic queue_set(input logic [12:0] secs);
		stim_t w;
		w = junk_word();
		w.action = ACT_SET;
		w.seconds = secs;
		words_to_send.push_back(w);
	endtask

	task automatic queue_text(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
			input logic [7:0] c3, input logic [15:0] dur, input logic [31:0] ms);
		stim_t w;
		w = junk_word();
		w.action  = ACT_TEXT;
		w.chars   = {c3, c2, c1, c0};
		w.text_ms = dur;
		w.now_ms  = ms;
		words_to_send.push_back(w);
	endtask

	function automatic logic [7:0] random_char();
		if ($urandom_range(0, 3) != 0)
			return LETTER_CODES[$urandom_range(0, 9)];
		return 8'($urandom);
	endfunction

	// Sender: offer words from the queue, hold each until taken, gap at random between.
	always @(negedge clk) begin : send
		if (arst_n) begin
			if (took_in)
				offering = 1'b0;
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (words_to_send.size() != 0) begin
					if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
						gap_left = $urandom_range(0, 4);
					end else begin
						on_bus = words_to_send.pop_front();
						offering = 1'b1;
					end
				end
			end
			s_axis_tvalid <= offering;
			s_axis_tdata  <= {3'b000, on_bus.text_ms, on_bus.chars, on_bus.seconds, on_bus.now_ms};
			s_axis_tuser  <= on_bus.action;
		end
	end

	// Long hold-off of the receiver, so the block backs up and stalls its input.
	always @(negedge clk) begin : hold_off
		if (arst_n && !hold_done && words_in >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: short random stalls on top of the hold-off.
	always @(negedge clk) begin : receive
		if (arst_n) begin
			if (stall_left > 0)
				stall_left--;
			else if (!calm && stalls_on && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 5);
			m_axis_tready <= (stall_left == 0) && (hold_left == 0);
		end
	end

	// Monitor: predict on every taken input word, check every taken output word.
	always @(posedge clk) begin : watch
		shown_t due;
		if (arst_n) begin
			took_in = s_axis_tvalid && s_axis_tready;
			if (took_in) begin
				advance_display(on_bus);
				words_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (digits_due.size() == 0) begin
					flag_mismatch($sformatf("word %h with nothing expected", m_axis_tdata));
				end else begin
					due = digits_due.pop_front();
					if (m_axis_tdata[7:0] !== due.segments)
						flag_mismatch($sformatf("segments %h, expected %h",
							m_axis_tdata[7:0], due.segments));
					if (m_axis_tdata[15:8] !== due.digit_enable)
						flag_mismatch($sformatf("digit_enable %h, expected %h",
							m_axis_tdata[15:8], due.digit_enable));
				end
			end
		end
	end

	// Hang guard: any correct run ends well inside this.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		int unsigned pick;
		int unsigned span;
		int unsigned offset;
		int unsigned stop;
		logic [31:0] start;
		logic [15:0] dur;
		stim_t       w;

		// Directed: 00:00 round including the silent wrap at position 4.
		repeat (5) queue_tick(32'd0);
		// largest legal count, then the top of the field range, which must saturate
		queue_set(13'd5999);
		queue_set(13'h1FFF);
		repeat (4) queue_tick($urandom);
		// text that starts just below the 2^32 wrap, longest duration
		queue_text("s", "o", "f", "a", 16'hFFFF, 32'hFFFF_FFF0);
		queue_tick(32'hFFFF_FFF8);                 // position 4: wraps, nothing shown
		queue_tick(32'h0000_0010);                 // elapsed counted across the wrap
		queue_tick(32'hFFFF_FFF0 + 32'h0000_FFFF); // exactly on the deadline: time shown
		queue_tick(32'hFFFF_FFF0 + 32'h0001_0000); // past it: leave text, nothing shown
		w = junk_word();
		w.action = ACT_UNUSED;
		words_to_send.push_back(w);
		queue_set(13'd61);
		// zero duration: first tick lands on the deadline, next one expires
		queue_text("r", "u", "n", "X", 16'd0, 32'd500);
		queue_tick(32'd500);
		queue_tick(32'd501);
		// unknown characters go blank
		queue_text("d", "e", 8'hFF, "t", 16'd10, 32'd1000);
		queue_tick(32'd1003);
		queue_tick(32'd1010);

		// Random: mostly well-formed time and text sequences, some noise.
		gen_ms = $urandom;
		stop = words_to_send.size() + RANDOM_WORDS;
		while (words_to_send.size() < stop) begin
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				queue_set(($urandom_range(0, 7) == 0) ? 13'($urandom_range(6000, 8191))
					: 13'($urandom_range(0, 5999)));
				repeat ($urandom_range(3, 12)) begin
					gen_ms = gen_ms + $urandom_range(0, 1000);
					queue_tick(gen_ms);
				end
			end else if (pick < 8) begin
				start = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200)
					: gen_ms;
				dur = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
				queue_text(random_char(), random_char(), random_char(), random_char(), dur, start);
				span = dur / 4 + 2;
				offset = 0;
				repeat ($urandom_range(2, 10)) begin
					case ($urandom_range(0, 9))
						0: offset = dur;          // right on the deadline
						1: offset = $urandom;     // anywhere on the wrapped clock
						default: offset = offset + $urandom_range(0, span);
					endcase
					queue_tick(start + offset);
				end
				gen_ms = start + offset;
			end else if (pick == 8) begin
				repeat ($urandom_range(1, 3)) words_to_send.push_back(junk_word());
			end else begin
				w = junk_word();
				w.action = ACT_UNUSED;
				words_to_send.push_back(w);
			end
		end
		total_words = words_to_send.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_in != total_words) @(posedge clk);
		while (digits_due.size() != 0) @(posedge clk);
		// let any stray word surface before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
